[sv/pltob_pkg.sv]
package pltob_pkg;

   localparam int MAX_PRICE_DEFAULT = 1000;
   localparam int SIZE_BITS_DEFAULT = 32;
   localparam int WORD_BITS = 64;
   localparam int BIT_BITS = 6;

   localparam int OP_BITS = 3;
   localparam int PRICE_BITS = 10;
   localparam int SIZE_IN_BITS = 32;

   localparam logic [OP_BITS-1:0] OP_SNAP_BEGIN = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SNAP_LEVEL = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SNAP_END = 3'd2;
   localparam logic [OP_BITS-1:0] OP_LEVEL_CHANGE = 3'd3;
   localparam logic [OP_BITS-1:0] OP_HINT = 3'd4;

   typedef struct packed {
      logic capture;
      logic execute;
      logic hint;
      logic scan_step;
      logic latch;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic price_ok;
      logic scan_last;
   } status_type;

   function automatic logic [BIT_BITS-1:0] high_bit(input logic [WORD_BITS-1:0] w);
      logic [BIT_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (w[i]) begin
            r = BIT_BITS'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [BIT_BITS-1:0] low_bit(input logic [WORD_BITS-1:0] w);
      logic [BIT_BITS-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = BIT_BITS'(i);
         end
      end
      return r;
   endfunction

endpackage

[sv/pltob_ram.sv]
module pltob_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[sv/pltob_ctrl.sv]
module pltob_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  pltob_pkg::status_type status,
   output pltob_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_HINT = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_LATCH = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            if (status.op == pltob_pkg::OP_SNAP_END ||
                (status.op == pltob_pkg::OP_LEVEL_CHANGE && status.price_ok)) begin
               state_in = ST_SCAN;
            end else if (status.op == pltob_pkg::OP_HINT) begin
               state_in = ST_HINT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_HINT: begin
            cmd.hint = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = valid_ff;

endmodule

[sv/pltob_dp.sv]
module pltob_dp #(
   parameter int MAX_PRICE = pltob_pkg::MAX_PRICE_DEFAULT,
   parameter int SIZE_BITS = pltob_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pltob_pkg::cmd_type    cmd,
   output pltob_pkg::status_type status,
   input  logic [63:0]           req_tdata,
   input  logic [3:0]            req_tuser,
   output logic [87:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   localparam int DEPTH = MAX_PRICE + 1;
   localparam int AW = $clog2(DEPTH);
   localparam int NW = (DEPTH + pltob_pkg::WORD_BITS - 1) / pltob_pkg::WORD_BITS;
   localparam int WW = (NW > 1) ? $clog2(NW) : 1;
   localparam int PB = pltob_pkg::PRICE_BITS;
   localparam int SB = pltob_pkg::SIZE_IN_BITS;

   logic [pltob_pkg::OP_BITS-1:0] op_ff;
   logic                          bid_ff;
   logic [PB-1:0]                 price_ff, hb_ff, ha_ff;
   logic [SIZE_BITS-1:0]          size_ff;

   logic [pltob_pkg::WORD_BITS-1:0] bid_occ_ff [NW];
   logic [pltob_pkg::WORD_BITS-1:0] ask_occ_ff [NW];
   logic [pltob_pkg::WORD_BITS-1:0] bid_occ_in [NW];
   logic [pltob_pkg::WORD_BITS-1:0] ask_occ_in [NW];

   logic [WW-1:0]        k_ff;
   logic                 do_b_ff, do_a_ff, fnd_b_ff, fnd_a_ff;
   logic [AW-1:0]        cand_b_ff, cand_a_ff;
   logic [AW-1:0]        top_bid_ff;
   logic [AW-1:0]        top_ask_ff;
   logic [SIZE_BITS-1:0] top_bid_size_ff, top_ask_size_ff;
   logic                 snap_ff, ign_ff;
   logic [87:0]          out_data_ff;
   logic [1:0]           out_user_ff;

   logic [AW-1:0]        addr, hb_addr, ha_addr;
   logic [WW-1:0]        b_idx, a_idx;
   logic [pltob_pkg::WORD_BITS-1:0] b_word, a_word;
   logic                 price_ok, size_nz, do_write, hit_b, hit_a;
   logic [SIZE_BITS-1:0] rd_b, rd_a;

   function automatic logic in_range(input logic [PB-1:0] p);
      return (p != '0) && ({22'd0, p} <= 32'(MAX_PRICE));
   endfunction

   function automatic logic [WW-1:0] word_of(input logic [AW-1:0] a);
      return WW'(a >> pltob_pkg::BIT_BITS);
   endfunction

   assign addr = AW'(price_ff);
   assign hb_addr = AW'(hb_ff);
   assign ha_addr = AW'(ha_ff);
   assign price_ok = in_range(price_ff);
   assign size_nz = (size_ff != '0);
   assign do_write = cmd.execute && price_ok &&
                     ((op_ff == pltob_pkg::OP_SNAP_LEVEL && size_nz) ||
                      op_ff == pltob_pkg::OP_LEVEL_CHANGE);

   assign hit_b = in_range(hb_ff) &&
                  bid_occ_ff[word_of(hb_addr)][hb_addr[pltob_pkg::BIT_BITS-1:0]];
   assign hit_a = in_range(ha_ff) &&
                  ask_occ_ff[word_of(ha_addr)][ha_addr[pltob_pkg::BIT_BITS-1:0]];

   assign b_idx = WW'(NW - 1) - k_ff;
   assign a_idx = k_ff;
   assign b_word = bid_occ_ff[b_idx];
   assign a_word = ask_occ_ff[a_idx];

   assign status.op = op_ff;
   assign status.price_ok = price_ok;
   assign status.scan_last = (k_ff == WW'(NW - 1));

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         bid_occ_in[i] = bid_occ_ff[i];
         ask_occ_in[i] = ask_occ_ff[i];
         if (cmd.execute && op_ff == pltob_pkg::OP_SNAP_BEGIN) begin
            bid_occ_in[i] = '0;
            ask_occ_in[i] = '0;
         end
      end
      if (do_write) begin
         if (bid_ff) begin
            bid_occ_in[word_of(addr)][addr[pltob_pkg::BIT_BITS-1:0]] = size_nz;
         end else begin
            ask_occ_in[word_of(addr)][addr[pltob_pkg::BIT_BITS-1:0]] = size_nz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) begin
            bid_occ_ff[i] <= '0;
            ask_occ_ff[i] <= '0;
         end
         top_bid_ff <= '0;
         top_ask_ff <= '0;
         top_bid_size_ff <= '0;
         top_ask_size_ff <= '0;
         snap_ff <= 1'b0;
      end else begin
         bid_occ_ff <= bid_occ_in;
         ask_occ_ff <= ask_occ_in;
         if (cmd.execute && op_ff == pltob_pkg::OP_SNAP_END) begin
            snap_ff <= 1'b1;
         end
         if (cmd.latch) begin
            top_bid_ff <= fnd_b_ff ? cand_b_ff : '0;
            top_bid_size_ff <= fnd_b_ff ? rd_b : '0;
            top_ask_ff <= fnd_a_ff ? cand_a_ff : '0;
            top_ask_size_ff <= fnd_a_ff ? rd_a : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_tuser[2:0];
         bid_ff <= req_tuser[3];
         price_ff <= req_tdata[9:0];
         size_ff <= SIZE_BITS'(req_tdata[41:10]);
         hb_ff <= req_tdata[51:42];
         ha_ff <= req_tdata[61:52];
      end
      if (cmd.execute) begin
         ign_ff <= (op_ff == pltob_pkg::OP_SNAP_LEVEL && (!price_ok || !size_nz)) ||
                   (op_ff == pltob_pkg::OP_LEVEL_CHANGE && !price_ok);
         k_ff <= '0;
         do_b_ff <= 1'b1;
         do_a_ff <= 1'b1;
         fnd_b_ff <= 1'b0;
         fnd_a_ff <= 1'b0;
      end
      if (cmd.hint) begin
         do_b_ff <= !hit_b;
         do_a_ff <= !hit_a;
         fnd_b_ff <= hit_b;
         fnd_a_ff <= hit_a;
         cand_b_ff <= hb_addr;
         cand_a_ff <= ha_addr;
      end
      if (cmd.scan_step) begin
         k_ff <= k_ff + 1'b1;
         if (do_b_ff && !fnd_b_ff && (b_word != '0)) begin
            fnd_b_ff <= 1'b1;
            cand_b_ff <= AW'({b_idx, pltob_pkg::high_bit(b_word)});
         end
         if (do_a_ff && !fnd_a_ff && (a_word != '0)) begin
            fnd_a_ff <= 1'b1;
            cand_a_ff <= AW'({a_idx, pltob_pkg::low_bit(a_word)});
         end
      end
      if (cmd.load_out) begin
         out_data_ff <= {4'd0, SB'(top_ask_size_ff), PB'(top_ask_ff),
                         SB'(top_bid_size_ff), PB'(top_bid_ff)};
         out_user_ff <= {ign_ff, snap_ff};
      end
   end

   pltob_ram #(.WIDTH(SIZE_BITS), .DEPTH(DEPTH)) u_bid_ram (
      .clock(clock),
      .we(do_write && bid_ff),
      .waddr(addr),
      .wdata(size_ff),
      .raddr(cand_b_ff),
      .rdata(rd_b)
   );

   pltob_ram #(.WIDTH(SIZE_BITS), .DEPTH(DEPTH)) u_ask_ram (
      .clock(clock),
      .we(do_write && !bid_ff),
      .waddr(addr),
      .wdata(size_ff),
      .raddr(cand_a_ff),
      .rdata(rd_a)
   );

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

endmodule

[sv/price_ladder_top_of_book.sv]
// Top-of-book price ladder: one occupancy bitmap and one size memory per side over prices
// 1..MAX_PRICE. Each transfer carries one operation (snapshot begin, snapshot level, snapshot
// end, level change, best hint) and returns one result with the best bid and ask prices and
// sizes, the snapshot flag and the ignored flag. One item is handled at a time. Snapshot begin,
// snapshot level, rejected items and unknown codes go straight to the result; items
// that search the ladders (snapshot end, valid level changes, hints) scan, walking
// one 64-bit occupancy word per side per cycle; hints first check the hinted prices.
module price_ladder_top_of_book #(
   parameter int MAX_PRICE = pltob_pkg::MAX_PRICE_DEFAULT,
   parameter int SIZE_BITS = pltob_pkg::SIZE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // price, size, hint_bid, hint_ask, zero pad
   input  logic [3:0]  req_tuser,  // operation, is_bid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // bid price, bid size, ask price, ask size, zero pad
   output logic [1:0]  rsp_tuser   // snapshot_seen, ignored
);

   pltob_pkg::cmd_type    cmd;
   pltob_pkg::status_type status;

   pltob_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status(status),
      .cmd(cmd)
   );

   pltob_dp #(.MAX_PRICE(MAX_PRICE), .SIZE_BITS(SIZE_BITS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule
